// ===== hdl/vzr_pkg.sv =====
package vzr_pkg;

  localparam int unsigned DimBitsDefault  = 16;
  localparam int unsigned FracBitsDefault = 16;

endpackage

// ===== hdl/vzr_if.sv =====
interface vzr_in_if #(
  parameter int unsigned DIM_BITS  = vzr_pkg::DimBitsDefault,
  parameter int unsigned FRAC_BITS = vzr_pkg::FracBitsDefault
);
  logic                      valid;
  logic                      ready;
  logic [DIM_BITS-1:0]       image_width;
  logic [DIM_BITS-1:0]       image_height;
  logic [DIM_BITS-1:0]       display_x;
  logic [DIM_BITS-1:0]       display_y;
  logic [DIM_BITS-1:0]       disp_width;
  logic [DIM_BITS-1:0]       disp_height;
  logic                      zoom_enable;
  logic                      stretch_enable;
  logic [FRAC_BITS+7:0]      zoom_ratio;
  logic signed [FRAC_BITS+1:0] pan_horizontal;
  logic signed [FRAC_BITS+1:0] pan_vertical;

  modport source (output valid, image_width, image_height, display_x, display_y,
                  disp_width, disp_height, zoom_enable, stretch_enable,
                  zoom_ratio, pan_horizontal, pan_vertical, input ready);
  modport sink (input valid, image_width, image_height, display_x, display_y,
                disp_width, disp_height, zoom_enable, stretch_enable,
                zoom_ratio, pan_horizontal, pan_vertical, output ready);
endinterface

interface vzr_out_if #(
  parameter int unsigned DIM_BITS = vzr_pkg::DimBitsDefault
);
  logic                valid;
  logic                ready;
  logic [DIM_BITS:0]   src_x;
  logic [DIM_BITS:0]   src_y;
  logic [DIM_BITS-1:0] src_width;
  logic [DIM_BITS-1:0] src_height;
  logic [DIM_BITS:0]   dst_x;
  logic [DIM_BITS:0]   dst_y;
  logic [DIM_BITS-1:0] dst_width;
  logic [DIM_BITS-1:0] dst_height;
  logic                degenerate;

  modport source (output valid, src_x, src_y, src_width, src_height, dst_x, dst_y,
                  dst_width, dst_height, degenerate, input ready);
  modport sink (input valid, src_x, src_y, src_width, src_height, dst_x, dst_y,
                dst_width, dst_height, degenerate, output ready);
endinterface

// ===== hdl/vzr_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with sideband
module vzr_div #(
  parameter int unsigned NUM_BITS = 32,
  parameter int unsigned DEN_BITS = 16,
  parameter int unsigned SB_BITS  = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [NUM_BITS-1:0] num_i,
  input  logic [DEN_BITS-1:0] den_i,
  input  logic [SB_BITS-1:0]  sb_i,
  output logic                valid_o,
  output logic [NUM_BITS-1:0] quo_o,
  output logic [SB_BITS-1:0]  sb_o
);
  localparam int unsigned RemBits = DEN_BITS + 1;

  logic [NUM_BITS:1]               vld_q;
  logic [NUM_BITS-1:0]             num_q [1:NUM_BITS];
  logic [RemBits-1:0]              rem_q [1:NUM_BITS];
  logic [DEN_BITS-1:0]             den_q [1:NUM_BITS];
  logic [SB_BITS-1:0]              sb_q  [1:NUM_BITS];

  // one stage per quotient bit, numerator shifts out msb first
  for (genvar s = 0; s < NUM_BITS; s++) begin : g_stage
    logic                vld_s;
    logic [NUM_BITS-1:0] num_s;
    logic [RemBits-1:0]  rem_s;
    logic [DEN_BITS-1:0] den_s;
    logic [SB_BITS-1:0]  sb_s;
    logic [RemBits:0]  trial;
    logic [RemBits-1:0] rem_d;
    logic [NUM_BITS-1:0] num_d;

    // first stage takes the ports, later ones the previous stage
    if (s == 0) begin : g_first
      assign vld_s = valid_i;
      assign num_s = num_i;
      assign rem_s = '0;
      assign den_s = den_i;
      assign sb_s  = sb_i;
    end else begin : g_next
      assign vld_s = vld_q[s];
      assign num_s = num_q[s];
      assign rem_s = rem_q[s];
      assign den_s = den_q[s];
      assign sb_s  = sb_q[s];
    end

    always_comb begin
      trial = {rem_s, num_s[NUM_BITS-1]};
      if (trial >= {2'b00, den_s}) begin
        rem_d = RemBits'(trial - {2'b00, den_s});
        num_d = {num_s[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_d = RemBits'(trial);
        num_d = {num_s[NUM_BITS-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[s+1] <= vld_s;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= num_d;
        rem_q[s+1] <= rem_d;
        den_q[s+1] <= den_s;
        sb_q[s+1]  <= sb_s;
      end
    end
  end

  assign valid_o = vld_q[NUM_BITS];
  assign quo_o   = num_q[NUM_BITS];
  assign sb_o    = sb_q[NUM_BITS];
endmodule

// ===== hdl/viewport_zoom_rect_calc_core.sv =====
// Viewport zoom rectangle calculator: one request enters per cycle while the
// output is not stalled; its source and destination rectangles are computed by
// two bit-per-stage divider pipelines of 2*DIM_BITS stages each (canvas aspect,
// then destination fit) plus seven register stages.
// The whole pipe advances together and holds on a stalled output, so throughput
// is one item per cycle while the output is not stalled.
module viewport_zoom_rect_calc_core #(
  parameter int unsigned DIM_BITS  = vzr_pkg::DimBitsDefault,
  parameter int unsigned FRAC_BITS = vzr_pkg::FracBitsDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  vzr_in_if.sink   in_i,
  vzr_out_if.source out_o
);
  localparam int unsigned D  = DIM_BITS;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned ZB = F + 8;
  localparam int unsigned PB = F + 2;
  localparam int unsigned NB = 2 * D;

  logic en;
  logic out_vld_q;
  assign en       = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  // stage a: pick aspect numerator and divisor
  typedef struct packed {
    logic [D-1:0] iw, ih, dx, dy, dw, dh;
    logic zoom, stretch, wide;
    logic [ZB-1:0] zr;
    logic [PB-1:0] ph, pv;
  } req_t;

  req_t a_q;
  logic a_vld_q;
  logic [NB-1:0] a_num_q;
  logic [D-1:0] a_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (en) a_vld_q <= in_i.valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q.iw <= in_i.image_width;   a_q.ih <= in_i.image_height;
      a_q.dx <= in_i.display_x;     a_q.dy <= in_i.display_y;
      a_q.dw <= in_i.disp_width;    a_q.dh <= in_i.disp_height;
      a_q.zoom <= in_i.zoom_enable; a_q.stretch <= in_i.stretch_enable;
      a_q.wide <= in_i.image_width > in_i.image_height;
      a_q.zr <= in_i.zoom_ratio;
      a_q.ph <= in_i.pan_horizontal; a_q.pv <= in_i.pan_vertical;
      if (in_i.image_width > in_i.image_height) begin
        a_num_q <= NB'(in_i.image_width) * NB'(in_i.disp_height);
        a_den_q <= in_i.disp_width;
      end else begin
        a_num_q <= NB'(in_i.image_height) * NB'(in_i.disp_width);
        a_den_q <= in_i.disp_height;
      end
    end
  end

  // aspect divide
  logic b_vld;
  logic [NB-1:0] b_quo;
  req_t b_req;
  vzr_div #(.NUM_BITS(NB), .DEN_BITS(D), .SB_BITS($bits(req_t))) u_div_aspect (
    .clk_i, .rst_ni, .en_i(en), .valid_i(a_vld_q), .num_i(a_num_q),
    .den_i(a_den_q), .sb_i(a_q), .valid_o(b_vld), .quo_o(b_quo), .sb_o(b_req)
  );

  // stage c: canvas sides before zoom (quotient < 2^(2D), clamp-free: fits NB)
  logic c_vld_q, c_deg_q;
  req_t c_q;
  logic [NB-1:0] c_cw_q, c_ch_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= 1'b0;
    else if (en) c_vld_q <= b_vld;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      c_q <= b_req;
      c_deg_q <= b_req.wide ? (b_req.dw == '0) : (b_req.dh == '0);
      c_cw_q <= b_req.wide ? NB'(b_req.iw) : b_quo;
      c_ch_q <= b_req.wide ? b_quo : NB'(b_req.ih);
    end
  end

  // stage d: zoom products (c * z / 2^F)
  localparam int unsigned ZP = NB + ZB;
  logic d_vld_q, d_deg_q;
  req_t d_q;
  logic [ZP-1:0] d_cw_q, d_ch_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) d_vld_q <= 1'b0;
    else if (en) d_vld_q <= c_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      d_q <= c_q;
      d_deg_q <= c_deg_q;
      if (c_q.zoom) begin
        d_cw_q <= ZP'(c_cw_q) * ZP'(c_q.zr);
        d_ch_q <= ZP'(c_ch_q) * ZP'(c_q.zr);
      end else begin
        d_cw_q <= ZP'(c_cw_q) << F;
        d_ch_q <= ZP'(c_ch_q) << F;
      end
    end
  end

  // stage e: canvas final, clip source
  localparam int unsigned CW = ZP - F;
  logic [CW-1:0] e_cw, e_ch;
  assign e_cw = d_cw_q[ZP-1:F];
  assign e_ch = d_ch_q[ZP-1:F];
  logic e_vld_q, e_deg_q;
  req_t e_q;
  logic [CW-1:0] e_cw_q, e_ch_q;
  logic [D-1:0] e_sw_q, e_sh_q, e_sx_q, e_sy_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) e_vld_q <= 1'b0;
    else if (en) e_vld_q <= d_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      e_q <= d_q;
      e_cw_q <= e_cw; e_ch_q <= e_ch;
      e_deg_q <= d_deg_q || e_cw == '0 || e_ch == '0;
      if (CW'(d_q.iw) > e_cw) begin
        e_sw_q <= D'(e_cw);
        e_sx_q <= D'((CW'(d_q.iw) - e_cw) >> 1);
      end else begin
        e_sw_q <= d_q.iw; e_sx_q <= '0;
      end
      if (CW'(d_q.ih) > e_ch) begin
        e_sh_q <= D'(e_ch);
        e_sy_q <= D'((CW'(d_q.ih) - e_ch) >> 1);
      end else begin
        e_sh_q <= d_q.ih; e_sy_q <= '0;
      end
    end
  end

  // stage f: pan products
  logic [PB-1:0] pmag_h, pmag_v;
  assign pmag_h = e_q.ph[PB-1] ? PB'(-e_q.ph) : e_q.ph;
  assign pmag_v = e_q.pv[PB-1] ? PB'(-e_q.pv) : e_q.pv;
  localparam int unsigned PP = D + PB;
  logic f_vld_q, f_deg_q;
  req_t f_q;
  logic [CW-1:0] f_cw_q, f_ch_q;
  logic [D-1:0] f_sw_q, f_sh_q, f_sx_q, f_sy_q;
  logic [PP-1:0] f_ph_q, f_pv_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) f_vld_q <= 1'b0;
    else if (en) f_vld_q <= e_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      f_q <= e_q; f_deg_q <= e_deg_q;
      f_cw_q <= e_cw_q; f_ch_q <= e_ch_q;
      f_sw_q <= e_sw_q; f_sh_q <= e_sh_q;
      f_sx_q <= e_sx_q; f_sy_q <= e_sy_q;
      f_ph_q <= PP'(e_sx_q) * PP'(pmag_h);
      f_pv_q <= PP'(e_sy_q) * PP'(pmag_v);
    end
  end

  // stage g: panned origin, fit numerators
  localparam int unsigned DP = PP - F;
  logic [DP-1:0] dlt_h, dlt_v;
  logic [DP:0] px, py;
  assign dlt_h = f_ph_q[PP-1:F];
  assign dlt_v = f_pv_q[PP-1:F];
  always_comb begin
    px = (DP+1)'(f_sx_q);
    py = (DP+1)'(f_sy_q);
    if (f_q.zoom) begin
      if (!f_q.ph[PB-1]) px = (DP+1)'(f_sx_q) + (DP+1)'(dlt_h);
      else if (dlt_h > DP'(f_sx_q)) px = '0;
      else px = (DP+1)'(f_sx_q) - (DP+1)'(dlt_h);
      if (!f_q.pv[PB-1]) py = (DP+1)'(f_sy_q) + (DP+1)'(dlt_v);
      else if (dlt_v > DP'(f_sy_q)) py = '0;
      else py = (DP+1)'(f_sy_q) - (DP+1)'(dlt_v);
    end
  end

  typedef struct packed {
    logic deg, stretch;
    logic [D:0] sx, sy;
    logic [D-1:0] sw, sh, dx, dy, dw, dh;
  } res_t;

  logic g_vld_q;
  res_t g_q;
  logic [NB-1:0] g_nw_q, g_nh_q;
  logic [CW-1:0] g_cw_q, g_ch_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) g_vld_q <= 1'b0;
    else if (en) g_vld_q <= f_vld_q;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      g_q.deg <= f_deg_q; g_q.stretch <= f_q.stretch;
      g_q.sx <= (D+1)'(px); g_q.sy <= (D+1)'(py);
      g_q.sw <= f_sw_q; g_q.sh <= f_sh_q;
      g_q.dx <= f_q.dx; g_q.dy <= f_q.dy; g_q.dw <= f_q.dw; g_q.dh <= f_q.dh;
      g_nw_q <= NB'(f_sw_q) * NB'(f_q.dw);
      g_nh_q <= NB'(f_sh_q) * NB'(f_q.dh);
      g_cw_q <= f_cw_q; g_ch_q <= f_ch_q;
    end
  end

  // fit divides: numerator < 2^(2D); a canvas wider than that gives zero
  logic [NB-1:0] dw_den_n, dh_den_n;
  logic h_vld, v_vld;
  logic [NB-1:0] h_quo, v_quo;
  res_t h_res;
  logic [0:0] v_sb;
  vzr_div #(.NUM_BITS(NB), .DEN_BITS(CW), .SB_BITS($bits(res_t))) u_div_w (
    .clk_i, .rst_ni, .en_i(en), .valid_i(g_vld_q), .num_i(g_nw_q),
    .den_i(g_cw_q), .sb_i(g_q), .valid_o(h_vld), .quo_o(h_quo), .sb_o(h_res)
  );
  vzr_div #(.NUM_BITS(NB), .DEN_BITS(CW), .SB_BITS(1)) u_div_h (
    .clk_i, .rst_ni, .en_i(en), .valid_i(g_vld_q), .num_i(g_nh_q),
    .den_i(g_ch_q), .sb_i(g_q.deg), .valid_o(v_vld), .quo_o(v_quo), .sb_o(v_sb)
  );
  assign dw_den_n = h_quo;
  assign dh_den_n = v_quo;

  // output stage: centre destination
  logic [D-1:0] ow, oh;
  logic [D:0] ox, oy;
  always_comb begin
    ow = D'(dw_den_n);
    oh = D'(dh_den_n);
    ox = (D+1)'(h_res.dx);
    oy = (D+1)'(h_res.dy);
    if (h_res.stretch) begin
      ow = h_res.dw; oh = h_res.dh;
    end else begin
      if (dw_den_n < NB'(h_res.dw))
        ox = (D+1)'(h_res.dx) + (D+1)'((h_res.dw - ow) >> 1);
      if (dh_den_n < NB'(h_res.dh))
        oy = (D+1)'(h_res.dy) + (D+1)'((h_res.dh - oh) >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (en) out_vld_q <= h_vld;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_o.degenerate <= h_res.deg;
      if (h_res.deg) begin
        out_o.src_x <= '0; out_o.src_y <= '0;
        out_o.src_width <= '0; out_o.src_height <= '0;
        out_o.dst_x <= '0; out_o.dst_y <= '0;
        out_o.dst_width <= '0; out_o.dst_height <= '0;
      end else begin
        out_o.src_x <= h_res.sx; out_o.src_y <= h_res.sy;
        out_o.src_width <= h_res.sw; out_o.src_height <= h_res.sh;
        out_o.dst_x <= ox; out_o.dst_y <= oy;
        out_o.dst_width <= ow; out_o.dst_height <= oh;
      end
    end
  end
  assign out_o.valid = out_vld_q;

  // lanes of the two fit dividers stay in step
  a_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_vld == v_vld && (!h_vld || v_sb[0] == h_res.deg))
    else $error("fit dividers out of step");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |=> out_vld_q) else $error("result dropped");
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_o.degenerate |-> out_o.src_width == '0 && out_o.dst_width == '0)
    else $error("degenerate result not cleared");
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(g_vld_q)) else $error("pipe moved during stall");
  a_src_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    e_vld_q && !e_deg_q |-> CW'(e_sw_q) <= e_cw_q) else $error("source not clipped");
endmodule
